// ===== rtl/gwpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gwpr_pkg: shared types and constants of the grid wave path router
// Item structs, cell control and status groups, direction and state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gwpr_pkg;

    // Grid store geometry and field widths
    localparam int COORD_W  = 3;
    localparam int DIST_W   = 7;
    localparam int STEP_W   = 6;
    localparam int NUM_DIRS = 4;

    // Neighbour directions, in trace priority order
    localparam int DIR_XM = 0;
    localparam int DIR_XP = 1;
    localparam int DIR_YM = 2;
    localparam int DIR_YP = 3;

    // Operation codes
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [DIST_W-1:0]  t_dist;
    typedef logic [STEP_W-1:0]  t_step;

    typedef struct packed {
        logic   operation;
        t_coord cell_x;
        t_coord cell_y;
        logic   occupied;
        t_coord target_x;
        t_coord target_y;
    } t_in_item;

    typedef struct packed {
        t_coord path_x;
        t_coord path_y;
        t_step  step_count;
        logic   found;
        logic   last;
    } t_out_item;

    // Broadcast control to every cell
    typedef struct packed {
        logic   set_we;
        logic   set_occ;
        logic   clear;
        logic   wave;
        logic   trace_start;
        logic   trace_step;
        t_coord pos_x;
        t_coord pos_y;
        t_coord tgt_x;
        t_coord tgt_y;
        t_dist  level;
    } t_cell_ctrl;

    // Status of one cell
    typedef struct packed {
        logic                reached;
        t_dist               wdist;
        logic                token;
        logic [NUM_DIRS-1:0] pass;
        logic                grow;
        logic                at_tgt;
    } t_cell_stat;

    // Status of the whole grid
    typedef struct packed {
        logic                tgt_hit;
        logic                added;
        logic [NUM_DIRS-1:0] pass_dir;
    } t_grid_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAVE,
        S_TRACE,
        S_MISS
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/gwpr_cell.sv =====
// ----------------------------------------------------------------------------
// gwpr_cell: one grid cell
// Holds occupancy, wave distance and the trace token; grows the wave from
// its neighbours and hands the trace token to the first nearer neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module gwpr_cell #(
    parameter logic [2:0] CELL_X = 3'd0,
    parameter logic [2:0] CELL_Y = 3'd0
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire gwpr_pkg::t_cell_ctrl                   i_ctrl,
    input  wire logic [gwpr_pkg::NUM_DIRS-1:0]          i_nbr_reached,
    input  wire logic [gwpr_pkg::NUM_DIRS-1:0][gwpr_pkg::DIST_W-1:0] i_nbr_dist,
    input  wire logic                                   i_tok_in,
    output gwpr_pkg::t_cell_stat                        o_stat
);
    import gwpr_pkg::*;

    logic  r_occ;
    logic  r_reached;
    t_dist r_dist;
    logic  r_token;

    logic                is_pos;
    logic                is_tgt;
    logic                grow;
    t_dist               dist_m1;
    logic [NUM_DIRS-1:0] nearer;
    logic [NUM_DIRS-1:0] pass;

    assign is_pos  = (i_ctrl.pos_x == CELL_X) && (i_ctrl.pos_y == CELL_Y);
    assign is_tgt  = (i_ctrl.tgt_x == CELL_X) && (i_ctrl.tgt_y == CELL_Y);
    assign grow    = i_ctrl.wave && !r_reached && !r_occ && (|i_nbr_reached);
    assign dist_m1 = r_dist - t_dist'(1);

    // First nearer neighbour in priority order takes the token
    always_comb begin
        for (int d = 0; d < NUM_DIRS; d++) begin
            nearer[d] = i_nbr_reached[d] && (i_nbr_dist[d] == dist_m1);
        end
        pass = '0;
        if (r_token) begin
            if (nearer[DIR_XM]) begin
                pass[DIR_XM] = 1'b1;
            end else if (nearer[DIR_XP]) begin
                pass[DIR_XP] = 1'b1;
            end else if (nearer[DIR_YM]) begin
                pass[DIR_YM] = 1'b1;
            end else if (nearer[DIR_YP]) begin
                pass[DIR_YP] = 1'b1;
            end
        end
    end

    // Occupancy, wave and token state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= 1'b0;
            r_reached <= 1'b0;
            r_token   <= 1'b0;
        end else begin
            if (i_ctrl.set_we && is_pos) begin
                r_occ <= i_ctrl.set_occ;
            end
            if (i_ctrl.clear) begin
                r_reached <= is_pos;
            end else if (grow) begin
                r_reached <= 1'b1;
            end
            if (i_ctrl.trace_start) begin
                r_token <= is_tgt;
            end else if (i_ctrl.trace_step) begin
                r_token <= i_tok_in;
            end
        end
    end

    // Distance needs no reset: only read where reached is set
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_dist <= t_dist'(1);
        end else if (grow) begin
            r_dist <= i_ctrl.level + t_dist'(1);
        end
    end

    assign o_stat.reached = r_reached;
    assign o_stat.wdist   = r_dist;
    assign o_stat.token   = r_token;
    assign o_stat.pass    = pass;
    assign o_stat.grow    = grow;
    assign o_stat.at_tgt  = r_reached && is_tgt;

endmodule

`default_nettype wire

// ===== rtl/gwpr_grid.sv =====
// ----------------------------------------------------------------------------
// gwpr_grid: square array of cells
// Wires each cell to its up to four neighbours and gathers target hit, wave
// growth and the token's step direction.
// ----------------------------------------------------------------------------
`default_nettype none

module gwpr_grid #(
    parameter int GRID_SIZE = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gwpr_pkg::t_cell_ctrl i_ctrl,
    output gwpr_pkg::t_grid_stat      o_stat
);
    import gwpr_pkg::*;

    localparam int CELLS = GRID_SIZE * GRID_SIZE;

    t_cell_stat                       st     [CELLS];
    logic [NUM_DIRS-1:0]              nr     [CELLS];
    logic [NUM_DIRS-1:0][DIST_W-1:0]  nd     [CELLS];
    logic [NUM_DIRS-1:0]              tp     [CELLS];

    // Cell array with neighbour links
    for (genvar gy = 0; gy < GRID_SIZE; gy++) begin : g_row
        for (genvar gx = 0; gx < GRID_SIZE; gx++) begin : g_col
            localparam int I = gy * GRID_SIZE + gx;

            for (genvar d = 0; d < NUM_DIRS; d++) begin : g_dir
                localparam int NX = gx + ((d == DIR_XP) ? 1 : 0) - ((d == DIR_XM) ? 1 : 0);
                localparam int NY = gy + ((d == DIR_YP) ? 1 : 0) - ((d == DIR_YM) ? 1 : 0);
                if (NX >= 0 && NX < GRID_SIZE && NY >= 0 && NY < GRID_SIZE) begin : g_in
                    localparam int NI = NY * GRID_SIZE + NX;
                    assign nr[I][d] = st[NI].reached;
                    assign nd[I][d] = st[NI].wdist;
                    // neighbour hands over through the opposite direction
                    assign tp[I][d] = st[NI].pass[d ^ 1];
                end else begin : g_edge
                    assign nr[I][d] = 1'b0;
                    assign nd[I][d] = '0;
                    assign tp[I][d] = 1'b0;
                end
            end

            gwpr_cell #(
                .CELL_X (3'(gx)),
                .CELL_Y (3'(gy))
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (i_ctrl),
                .i_nbr_reached (nr[I]),
                .i_nbr_dist    (nd[I]),
                .i_tok_in      (|tp[I]),
                .o_stat        (st[I])
            );
        end
    end

    // OR reduction of cell status
    always_comb begin
        o_stat = '0;
        for (int i = 0; i < CELLS; i++) begin
            o_stat.tgt_hit  = o_stat.tgt_hit | st[i].at_tgt;
            o_stat.added    = o_stat.added | st[i].grow;
            o_stat.pass_dir = o_stat.pass_dir | st[i].pass;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/grid_wave_path_router_top.sv =====
// ----------------------------------------------------------------------------
// grid_wave_path_router_top: Lee wave router over a grid of cells
// Set items write one cell's occupancy. Route items run a wave one
// distance level per cycle, then trace the token back to the source.
// ----------------------------------------------------------------------------
// Items are taken one at a time: a new item is accepted only in the idle
//   state, so a route holds off further items until its last result is
//   loaded. A miss gives its single result from the miss state, entered on
//   the wave step that adds no cell, once the output register is free.
// Reset (synchronous, active low) frees every cell.
`default_nettype none

module grid_wave_path_router_top #(
    parameter int GRID_SIZE = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire gwpr_pkg::t_in_item i_in_item,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output gwpr_pkg::t_out_item     o_out_item
);
    import gwpr_pkg::*;

    t_state    r_state,     n_state;
    t_coord    r_tx,        n_tx;
    t_coord    r_ty,        n_ty;
    t_coord    r_px,        n_px;
    t_coord    r_py,        n_py;
    t_dist     r_level,     n_level;
    t_step     r_step,      n_step;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item,  n_out_item;

    t_cell_ctrl ctrl;
    t_grid_stat gstat;
    logic       out_free;
    logic       route_inside;

    gwpr_grid #(
        .GRID_SIZE (GRID_SIZE)
    ) u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_stat  (gstat)
    );

    assign route_inside = ({1'b0, i_in_item.cell_x}   < 4'(GRID_SIZE)) &&
                          ({1'b0, i_in_item.cell_y}   < 4'(GRID_SIZE)) &&
                          ({1'b0, i_in_item.target_x} < 4'(GRID_SIZE)) &&
                          ({1'b0, i_in_item.target_y} < 4'(GRID_SIZE));

    assign out_free = !r_out_valid || i_out_ready;

    // Next state, cell control and result loading
    always_comb begin
        n_state     = r_state;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_px        = r_px;
        n_py        = r_py;
        n_level     = r_level;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        o_in_ready  = 1'b0;

        ctrl         = '0;
        ctrl.pos_x   = i_in_item.cell_x;
        ctrl.pos_y   = i_in_item.cell_y;
        ctrl.set_occ = i_in_item.occupied;
        ctrl.tgt_x   = r_tx;
        ctrl.tgt_y   = r_ty;
        ctrl.level   = r_level;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_item.operation == OP_SET) begin
                        ctrl.set_we = 1'b1;
                    end else if (route_inside) begin
                        ctrl.clear = 1'b1;
                        n_tx       = i_in_item.target_x;
                        n_ty       = i_in_item.target_y;
                        n_level    = t_dist'(1);
                        n_state    = S_WAVE;
                    end else begin
                        n_state = S_MISS;
                    end
                end
            end
            S_WAVE: begin
                if (gstat.tgt_hit) begin
                    ctrl.trace_start = 1'b1;
                    n_px    = r_tx;
                    n_py    = r_ty;
                    n_step  = STEP_W'(r_level - t_dist'(1));
                    n_state = S_TRACE;
                end else begin
                    ctrl.wave = 1'b1;
                    if (gstat.added) begin
                        n_level = r_level + t_dist'(1);
                    end else begin
                        n_state = S_MISS;
                    end
                end
            end
            S_TRACE: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_item.path_x     = r_px;
                    n_out_item.path_y     = r_py;
                    n_out_item.step_count = r_step;
                    n_out_item.found      = 1'b1;
                    n_out_item.last       = (r_step == '0);
                    if (r_step == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        ctrl.trace_step = 1'b1;
                        n_step = r_step - t_step'(1);
                        if (gstat.pass_dir[DIR_XM]) begin
                            n_px = r_px - t_coord'(1);
                        end else if (gstat.pass_dir[DIR_XP]) begin
                            n_px = r_px + t_coord'(1);
                        end else if (gstat.pass_dir[DIR_YM]) begin
                            n_py = r_py - t_coord'(1);
                        end else if (gstat.pass_dir[DIR_YP]) begin
                            n_py = r_py + t_coord'(1);
                        end
                    end
                end
            end
            S_MISS: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_item.path_x     = '0;
                    n_out_item.path_y     = '0;
                    n_out_item.step_count = '0;
                    n_out_item.found      = 1'b0;
                    n_out_item.last       = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_tx       <= n_tx;
        r_ty       <= n_ty;
        r_px       <= n_px;
        r_py       <= n_py;
        r_level    <= n_level;
        r_step     <= n_step;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== rtl/gwpr_checker.sv =====
// ----------------------------------------------------------------------------
// gwpr_checker: port-level assertions for the grid wave path router
// Output handshake holding, result field consistency and reset behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module gwpr_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire gwpr_pkg::t_out_item o_out_item
);
    import gwpr_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result item changed while stalled");

    // A miss is a single zeroed, last item
    a_miss_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |->
            o_out_item.last && (o_out_item.path_x == '0) &&
            (o_out_item.path_y == '0) && (o_out_item.step_count == '0))
        else $error("malformed not-found item");

    // On a found path, last marks exactly the source
    a_last_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.found |->
            (o_out_item.last == (o_out_item.step_count == '0)))
        else $error("last flag does not match step count");

    // Reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind grid_wave_path_router_top gwpr_checker u_gwpr_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for grid_wave_path_router_top
// Drives set-cell and route items into the router and keeps its own copy
// of the occupancy map. Each route is solved in the scoreboard with a
// breadth-first wave and a trace back from target to source. Every path
// cell that comes out is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gwpr_pkg::*;

    localparam int GRID         = 8;
    localparam int ITEM_TOTAL   = 270;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 150;

    // Path prediction and in-order checking of path cells
    class route_scoreboard;
        bit        blocked [GRID][GRID];
        t_dist     level [GRID][GRID];
        t_out_item expected_path [$];
        int        mismatch_count;

        function new();
            foreach (blocked[r, c]) blocked[r][c] = 1'b0;
            mismatch_count = 0;
        endfunction

        function bit on_grid(int x, int y);
            return x >= 0 && y >= 0 && x < GRID && y < GRID;
        endfunction

        function void step_to(int dir, int x, int y, output int nx, output int ny);
            nx = x;
            ny = y;
            case (dir)
                DIR_XM: nx = x - 1;
                DIR_XP: nx = x + 1;
                DIR_YM: ny = y - 1;
                DIR_YP: ny = y + 1;
                default: ;
            endcase
        endfunction

        function void add_path_cell(int x, int y, t_step steps, bit found, bit last);
            t_out_item entry;
            entry.path_x     = t_coord'(x);
            entry.path_y     = t_coord'(y);
            entry.step_count = steps;
            entry.found      = found;
            entry.last       = last;
            expected_path.push_back(entry);
        endfunction

        // Wave from the source, then trace back from the target
        function void plan_route(t_in_item it);
            int    sx, sy, tx, ty, x, y, d, nx, ny, px, py, n;
            int    wave_lvl;
            bit    grew, moved;
            t_dist cur_lvl;
            sx = it.cell_x;
            sy = it.cell_y;
            tx = it.target_x;
            ty = it.target_y;
            if (!on_grid(sx, sy) || !on_grid(tx, ty)) begin
                add_path_cell(0, 0, '0, 1'b0, 1'b1);
                return;
            end
            foreach (level[r, c]) level[r][c] = '0;
            // source is numbered whatever its occupancy
            level[sy][sx] = t_dist'(1);
            wave_lvl = 1;
            while (level[ty][tx] == '0 && wave_lvl < 127) begin
                grew = 1'b0;
                for (y = 0; y < GRID; y++) begin
                    for (x = 0; x < GRID; x++) begin
                        if (level[y][x] == t_dist'(wave_lvl)) begin
                            for (d = 0; d < NUM_DIRS; d++) begin
                                step_to(d, x, y, nx, ny);
                                if (on_grid(nx, ny) && !blocked[ny][nx] &&
                                    level[ny][nx] == '0) begin
                                    level[ny][nx] = t_dist'(wave_lvl + 1);
                                    grew = 1'b1;
                                end
                            end
                        end
                    end
                end
                if (!grew) break;
                wave_lvl++;
            end
            if (level[ty][tx] == '0) begin
                add_path_cell(0, 0, '0, 1'b0, 1'b1);
                return;
            end
            // trace: first neighbour one level nearer, in direction order
            px = tx;
            py = ty;
            for (n = 0; n < GRID * GRID; n++) begin
                cur_lvl = level[py][px];
                add_path_cell(px, py, t_step'(cur_lvl - 1), 1'b1, cur_lvl == t_dist'(1));
                if (cur_lvl <= t_dist'(1)) break;
                moved = 1'b0;
                for (d = 0; d < NUM_DIRS && !moved; d++) begin
                    step_to(d, px, py, nx, ny);
                    if (on_grid(nx, ny) && level[ny][nx] == cur_lvl - t_dist'(1)) begin
                        px    = nx;
                        py    = ny;
                        moved = 1'b1;
                    end
                end
                if (!moved) break;
            end
        endfunction

        function void note_item(t_in_item it);
            if (it.operation == OP_SET) begin
                if (on_grid(it.cell_x, it.cell_y))
                    blocked[it.cell_y][it.cell_x] = it.occupied;
            end else begin
                plan_route(it);
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_path.size() == 0) begin
                $error("path cell (%0d,%0d) with none expected", got.path_x, got.path_y);
                mismatch_count++;
                return;
            end
            want = expected_path.pop_front();
            compare_field("path_x", want.path_x, got.path_x);
            compare_field("path_y", want.path_y, got.path_y);
            compare_field("step_count", want.step_count, got.step_count);
            compare_field("found", want.found, got.found);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_path.size();
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    route_scoreboard sb;
    int sent_count    = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 45;
    int cycle_count   = 0;

    grid_wave_path_router_top #(
        .GRID_SIZE(GRID)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // Clock, 12 ns period
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checking
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_item);
    end

    // Run timeout
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("grid_wave_path_router_top verification failed");
            $finish;
        end
    end

    // Offer one item, with random idle cycles first, and wait for acceptance
    task automatic send_item(input t_in_item it);
        if (sent_count < ITEM_TOTAL / 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 45;
        end else if (sent_count < 2 * ITEM_TOTAL / 3) begin
            send_idle_pct = 45;
            recv_idle_pct = 24;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_item(it);
        sent_count++;
    endtask

    function automatic t_in_item rand_item();
        t_in_item it;
        it.operation = $urandom_range(1) ? OP_ROUTE : OP_SET;
        it.cell_x    = t_coord'($urandom_range(GRID - 1));
        it.cell_y    = t_coord'($urandom_range(GRID - 1));
        it.occupied  = 1'($urandom_range(1));
        it.target_x  = t_coord'($urandom_range(GRID - 1));
        it.target_y  = t_coord'($urandom_range(GRID - 1));
        return it;
    endfunction

    task automatic set_cell(input int x, input int y, input bit occ);
        t_in_item it;
        it           = rand_item();
        it.operation = OP_SET;
        it.cell_x    = t_coord'(x);
        it.cell_y    = t_coord'(y);
        it.occupied  = occ;
        send_item(it);
    endtask

    task automatic route(input int sx, input int sy, input int tx, input int ty);
        t_in_item it;
        it           = rand_item();
        it.operation = OP_ROUTE;
        it.cell_x    = t_coord'(sx);
        it.cell_y    = t_coord'(sy);
        it.target_x  = t_coord'(tx);
        it.target_y  = t_coord'(ty);
        send_item(it);
    endtask

    // Stimulus and end of run
    initial begin
        t_in_item it;
        int       pick, lane, gap, burst, i;
        bit       horiz;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: same cell, corner to corner both ways
        route(0, 0, 0, 0);
        route(0, 0, 7, 7);
        route(7, 7, 0, 0);
        // blocked target misses; blocked source still routes
        set_cell(7, 7, 1'b1);
        route(0, 0, 7, 7);
        route(7, 7, 7, 7);
        route(7, 7, 0, 0);
        // corner walled in: no route to it; then a route between the other corners
        set_cell(6, 7, 1'b1);
        set_cell(7, 6, 1'b1);
        set_cell(7, 7, 1'b0);
        route(0, 0, 7, 7);
        route(7, 0, 0, 7);
        set_cell(6, 7, 1'b0);
        set_cell(7, 6, 1'b0);
        // wall on column 4 with the gap at the bottom row forces a detour
        for (i = 0; i < GRID - 1; i++) set_cell(4, i, 1'b1);
        route(0, 0, 7, 0);

        // random: short bursts of sets then a route, walls, some noise
        while (sent_count < ITEM_TOTAL) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                horiz = 1'($urandom_range(1));
                lane  = $urandom_range(GRID - 1);
                gap   = $urandom_range(GRID - 1);
                for (i = 0; i < GRID; i++) begin
                    if (horiz) set_cell(i, lane, i != gap);
                    else       set_cell(lane, i, i != gap);
                end
            end else if (pick < 18) begin
                send_item(rand_item());
            end else begin
                burst = $urandom_range(3);
                for (i = 0; i < burst; i++)
                    set_cell($urandom_range(GRID - 1), $urandom_range(GRID - 1),
                             $urandom_range(99) < 35);
                it           = rand_item();
                it.operation = OP_ROUTE;
                pick         = $urandom_range(9);
                if (pick == 0) begin
                    it.target_x = it.cell_x;
                    it.target_y = it.cell_y;
                end else if (pick == 1) begin
                    it.cell_x   = $urandom_range(1) ? t_coord'(GRID - 1) : '0;
                    it.cell_y   = $urandom_range(1) ? t_coord'(GRID - 1) : '0;
                    it.target_x = ~it.cell_x;
                    it.target_y = ~it.cell_y;
                end
                send_item(it);
            end
        end
        in_valid <= 1'b0;

        // drain, then allow for any stray output
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("grid_wave_path_router_top verification clean");
        end else begin
            $display("grid_wave_path_router_top verification failed");
        end
        $finish;
    end

endmodule

// ===== grid_wave_path_router_top.f =====
rtl/gwpr_pkg.sv
rtl/gwpr_cell.sv
rtl/gwpr_grid.sv
rtl/grid_wave_path_router_top.sv
rtl/gwpr_checker.sv
sim/tb.sv
